[design/plc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_pkg
// Shared widths, codes and types of the point light contribution core.
// ----------------------------------------------------------------------------
package plc_pkg;

    // Squared distance is exact: three squares of 32-bit magnitudes.
    localparam int D2_W      = 66;
    // Dot product of a Q2.14 normal with a 33-bit difference vector.
    localparam int DOT_W     = 51;
    // Floor square root of the squared distance.
    localparam int ROOT_W    = 34;
    localparam int RAD_W     = 2 * ROOT_W;
    // N.L numerator, denominator of the attenuation division, range numerator.
    localparam int NDL_NUM_W = 63;
    localparam int DEN_W     = 63;
    localparam int RF_NUM_W  = 63;
    localparam int PNUM_W    = 64;
    localparam int RF2_W     = 31;
    localparam int NORM_FRAC = 14;
    localparam int NDL_FRAC  = 28;
    localparam int RF_FRAC   = 30;

    // What the final stage selects for an item.
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_ZERO  = 2'd0;
    localparam t_kind KIND_POWER = 2'd1;
    localparam t_kind KIND_CALC  = 2'd2;

endpackage

[design/plc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_if
// Valid/ready channels of the point light contribution core.
// ----------------------------------------------------------------------------
interface plc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] surf_x;
    logic signed [31:0] surf_y;
    logic signed [31:0] surf_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [31:0] light_x;
    logic signed [31:0] light_y;
    logic signed [31:0] light_z;
    logic        [31:0] light_range;
    logic        [31:0] light_power;
    logic        [31:0] falloff_coeff;

    modport source (
        output valid, surf_x, surf_y, surf_z, norm_x, norm_y, norm_z,
               light_x, light_y, light_z, light_range, light_power, falloff_coeff,
        input  ready
    );
    modport sink (
        input  valid, surf_x, surf_y, surf_z, norm_x, norm_y, norm_z,
               light_x, light_y, light_z, light_range, light_power, falloff_coeff,
        output ready
    );
endinterface

interface plc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] contribution;

    modport source (output valid, contribution, input ready);
    modport sink (input valid, contribution, output ready);
endinterface

[design/plc_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_isqrt
// Pipelined floor square root, one root bit per stage, with a sideband.
// ----------------------------------------------------------------------------
module plc_isqrt #(
    parameter int ROOT_W = 34,
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2*ROOT_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root,
    output logic [SIDE_W-1:0]     o_side
);
    logic                r_valid [ROOT_W];
    logic [2*ROOT_W-1:0] r_rad   [ROOT_W];
    logic [ROOT_W:0]     r_rem   [ROOT_W];
    logic [ROOT_W-1:0]   r_root  [ROOT_W];
    logic [SIDE_W-1:0]   r_side  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic                w_valid;
        logic [2*ROOT_W-1:0] w_rad;
        logic [ROOT_W:0]     w_rem;
        logic [ROOT_W-1:0]   w_root;
        logic [SIDE_W-1:0]   w_side;
        logic [ROOT_W+2:0]   w_try;
        logic [ROOT_W+2:0]   w_trial;
        logic [ROOT_W+2:0]   w_diff;
        logic                w_ge;

        if (k == 0) begin : g_head
            assign w_valid = i_valid;
            assign w_rad   = i_rad;
            assign w_rem   = '0;
            assign w_root  = '0;
            assign w_side  = i_side;
        end else begin : g_body
            assign w_valid = r_valid[k-1];
            assign w_rad   = r_rad[k-1];
            assign w_rem   = r_rem[k-1];
            assign w_root  = r_root[k-1];
            assign w_side  = r_side[k-1];
        end

        // Bring down the next two radicand bits and try the next root bit.
        assign w_try   = {w_rem, w_rad[2*ROOT_W-1 -: 2]};
        assign w_trial = {1'b0, w_root, 2'b01};
        assign w_ge    = (w_try >= w_trial);
        assign w_diff  = w_try - w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff[ROOT_W:0] : w_try[ROOT_W:0];
                r_root[k] <= {w_root[ROOT_W-2:0], w_ge};
                r_rad[k]  <= {w_rad[2*ROOT_W-3:0], 2'b00};
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];
endmodule

[design/plc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// ----------------------------------------------------------------------------
module plc_div #(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 63,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot,
    output logic [SIDE_W-1:0] o_side
);
    logic              r_valid [NUM_W];
    logic [NUM_W-1:0]  r_nq    [NUM_W];
    logic [DEN_W-1:0]  r_rem   [NUM_W];
    logic [DEN_W-1:0]  r_den   [NUM_W];
    logic [SIDE_W-1:0] r_side  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic              w_valid;
        logic [NUM_W-1:0]  w_nq;
        logic [DEN_W-1:0]  w_rem;
        logic [DEN_W-1:0]  w_den;
        logic [SIDE_W-1:0] w_side;
        logic [DEN_W:0]    w_try;
        logic [DEN_W:0]    w_diff;
        logic              w_ge;

        if (k == 0) begin : g_head
            assign w_valid = i_valid;
            assign w_nq    = i_num;
            assign w_rem   = '0;
            assign w_den   = i_den;
            assign w_side  = i_side;
        end else begin : g_body
            assign w_valid = r_valid[k-1];
            assign w_nq    = r_nq[k-1];
            assign w_rem   = r_rem[k-1];
            assign w_den   = r_den[k-1];
            assign w_side  = r_side[k-1];
        end

        // The numerator shifts out at the top while quotient bits enter below.
        assign w_try  = {w_rem, w_nq[NUM_W-1]};
        assign w_ge   = (w_try >= {1'b0, w_den});
        assign w_diff = w_try - {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff[DEN_W-1:0] : w_try[DEN_W-1:0];
                r_nq[k]   <= {w_nq[NUM_W-2:0], w_ge};
                r_den[k]  <= w_den;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_valid[NUM_W-1];
    assign o_quot  = r_nq[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];
endmodule

[design/point_light_contribution_core.sv]
`timescale 1ns / 1ps
// Throughput: one item per cycle while the output skid stage holds no spare
// result; the square root and three dividers are fully pipelined, one bit per
// stage, and the 64-stage attenuation divider is the deepest of them.
// Reset (synchronous, active low) clears every stage valid bit and the output
// skid stage; payload registers keep whatever they hold.
// ----------------------------------------------------------------------------
// point_light_contribution_core
// Diffuse contribution of one point light at one surface point, Q16.16.
// ----------------------------------------------------------------------------
module point_light_contribution_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plc_in_if.sink    i_item,
    plc_out_if.source o_item
);
    import plc_pkg::*;

    // Width of the squared distance once reduced to Q format, and of the
    // attenuation product built from it.
    localparam int S_W       = D2_W - FRAC_BITS;
    localparam int PROD_W    = 32 + S_W;
    localparam int TERM_W    = PROD_W - FRAC_BITS;
    localparam int CMP_W     = (TERM_W > DEN_W) ? TERM_W : DEN_W;
    localparam int OUT_SHIFT = NDL_FRAC - FRAC_BITS;
    // Distances below NEAR_LSB, 0.0001 rounded up to a whole LSB, count as sitting on the light.
    localparam int NEAR_LSB  = ((2 ** FRAC_BITS) + 9999) / 10000;
    localparam int NEAR_SQ   = NEAR_LSB * NEAR_LSB;

    // ------------------------------------------------------------------
    // Stage payloads.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [32:0] vx;
        logic [32:0] vy;
        logic [32:0] vz;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [31:0] range;
        logic [31:0] power;
        logic [31:0] atten;
    } t_s1;

    typedef struct packed {
        logic [63:0] sqx;
        logic [63:0] sqy;
        logic [63:0] sqz;
        logic [48:0] px;
        logic [48:0] py;
        logic [48:0] pz;
        logic [63:0] rsq;
        logic [31:0] range;
        logic [31:0] power;
        logic [31:0] atten;
    } t_s2;

    typedef struct packed {
        logic [D2_W-1:0]  d2;
        logic [DOT_W-1:0] dot;
        logic [63:0]      rsq;
        logic [31:0]      range;
        logic [31:0]      power;
        logic [31:0]      atten;
    } t_s3;

    // Sideband that rides alongside the square root.
    typedef struct packed {
        t_kind                kind;
        logic [NDL_NUM_W-1:0] dotsh;
        logic [S_W-1:0]       s;
        logic [31:0]          range;
        logic [31:0]          power;
        logic [31:0]          atten;
    } t_sq_side;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        t_sq_side         side;
    } t_s4;

    typedef struct packed {
        t_kind                kind;
        logic [NDL_NUM_W-1:0] dotsh;
        logic [ROOT_W-1:0]    d;
        logic [RF_NUM_W-1:0]  rnum;
        logic [31:0]          range;
        logic [31:0]          power;
        logic [63:0]          pp_lo;
        logic [S_W-1:0]       pp_hi;
    } t_s5;

    typedef struct packed {
        t_kind                kind;
        logic [NDL_NUM_W-1:0] dotsh;
        logic [ROOT_W-1:0]    d;
        logic [RF_NUM_W-1:0]  rnum;
        logic [31:0]          range;
        logic [31:0]          power;
        logic [DEN_W-1:0]     den;
    } t_s6;

    // Sideband of the N.L divider.
    typedef struct packed {
        t_kind       kind;
        logic [31:0] power;
        logic        range_nz;
    } t_ndl_side;

    typedef struct packed {
        t_kind            kind;
        logic [31:0]      power;
        logic             range_nz;
        logic [63:0]      pp_a;
        logic [31:0]      pp_b;
        logic [RF2_W-1:0] rf2;
        logic [DEN_W-1:0] den;
    } t_s7;

    // Sideband of the attenuation divider.
    typedef struct packed {
        t_kind            kind;
        logic [31:0]      power;
        logic             range_nz;
        logic [RF2_W-1:0] rf2;
    } t_b_side;

    typedef struct packed {
        logic [PNUM_W-1:0] pnum;
        logic [DEN_W-1:0]  den;
        t_b_side           side;
    } t_s8;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] power;
        logic        range_nz;
        logic [63:0] b;
        logic [62:0] pm_lo;
        logic [62:0] pm_hi;
    } t_s9;

    function automatic logic [31:0] f_mag(input logic [32:0] v);
        logic [32:0] neg;
        neg = -v;
        return v[32] ? neg[31:0] : v[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Flow control. The whole pipeline advances together unless the output
    // skid stage is holding a second result; then every stage holds.
    // ------------------------------------------------------------------
    logic        w_adv;
    logic        w_out_take;
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        r_spare_valid;
    logic [31:0] r_spare_data;

    assign w_adv        = !r_spare_valid;
    assign w_out_take   = r_out_valid && o_item.ready;
    assign i_item.ready = w_adv;

    // ------------------------------------------------------------------
    // Stage 1: difference vector from the surface point to the light.
    // ------------------------------------------------------------------
    logic r_s1_valid;
    t_s1  r_s1;
    t_s1  n_s1;

    always_comb begin
        n_s1.vx    = $signed({i_item.light_x[31], i_item.light_x})
                   - $signed({i_item.surf_x[31], i_item.surf_x});
        n_s1.vy    = $signed({i_item.light_y[31], i_item.light_y})
                   - $signed({i_item.surf_y[31], i_item.surf_y});
        n_s1.vz    = $signed({i_item.light_z[31], i_item.light_z})
                   - $signed({i_item.surf_z[31], i_item.surf_z});
        n_s1.nx    = i_item.norm_x;
        n_s1.ny    = i_item.norm_y;
        n_s1.nz    = i_item.norm_z;
        n_s1.range = i_item.light_range;
        n_s1.power = i_item.light_power;
        n_s1.atten = i_item.falloff_coeff;
    end

    // ------------------------------------------------------------------
    // Stage 2: squares of the components, normal products and range squared.
    // ------------------------------------------------------------------
    logic        r_s2_valid;
    t_s2         r_s2;
    t_s2         n_s2;
    logic [31:0] w_ax;
    logic [31:0] w_ay;
    logic [31:0] w_az;

    assign w_ax = f_mag(r_s1.vx);
    assign w_ay = f_mag(r_s1.vy);
    assign w_az = f_mag(r_s1.vz);

    always_comb begin
        n_s2.sqx   = w_ax * w_ax;
        n_s2.sqy   = w_ay * w_ay;
        n_s2.sqz   = w_az * w_az;
        n_s2.px    = $signed(r_s1.nx) * $signed(r_s1.vx);
        n_s2.py    = $signed(r_s1.ny) * $signed(r_s1.vy);
        n_s2.pz    = $signed(r_s1.nz) * $signed(r_s1.vz);
        n_s2.rsq   = r_s1.range * r_s1.range;
        n_s2.range = r_s1.range;
        n_s2.power = r_s1.power;
        n_s2.atten = r_s1.atten;
    end

    // ------------------------------------------------------------------
    // Stage 3: exact squared distance and N.v.
    // ------------------------------------------------------------------
    logic r_s3_valid;
    t_s3  r_s3;
    t_s3  n_s3;

    always_comb begin
        n_s3.d2    = D2_W'(r_s2.sqx) + D2_W'(r_s2.sqy) + D2_W'(r_s2.sqz);
        n_s3.dot   = DOT_W'($signed(r_s2.px)) + DOT_W'($signed(r_s2.py))
                   + DOT_W'($signed(r_s2.pz));
        n_s3.rsq   = r_s2.rsq;
        n_s3.range = r_s2.range;
        n_s3.power = r_s2.power;
        n_s3.atten = r_s2.atten;
    end

    // ------------------------------------------------------------------
    // Stage 4: classify the item. Out of range or facing away gives zero,
    // a point on the light gives the bare intensity, the rest is computed.
    // ------------------------------------------------------------------
    logic r_s4_valid;
    t_s4  r_s4;
    t_s4  n_s4;
    logic w_far;
    logic w_near;
    logic w_facing;

    assign w_far    = (r_s3.range != '0) && (r_s3.d2 > D2_W'(r_s3.rsq));
    assign w_near   = (r_s3.d2 < D2_W'(NEAR_SQ));
    assign w_facing = !r_s3.dot[DOT_W-1] && (r_s3.dot != '0);

    always_comb begin
        if (w_far) begin
            n_s4.side.kind = KIND_ZERO;
        end else if (w_near) begin
            n_s4.side.kind = KIND_POWER;
        end else if (!w_facing) begin
            n_s4.side.kind = KIND_ZERO;
        end else begin
            n_s4.side.kind = KIND_CALC;
        end
        n_s4.rad        = RAD_W'(r_s3.d2);
        n_s4.side.dotsh = {r_s3.dot[NDL_NUM_W-NORM_FRAC-1:0], {NORM_FRAC{1'b0}}};
        n_s4.side.s     = r_s3.d2[D2_W-1:FRAC_BITS];
        n_s4.side.range = r_s3.range;
        n_s4.side.power = r_s3.power;
        n_s4.side.atten = r_s3.atten;
    end

    // ------------------------------------------------------------------
    // Distance: floor square root of the squared distance.
    // ------------------------------------------------------------------
    logic              w_sq_valid;
    logic [ROOT_W-1:0] w_sq_root;
    t_sq_side          w_sq_side;

    plc_isqrt #(
        .ROOT_W (ROOT_W),
        .SIDE_W ($bits(t_sq_side))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_s4_valid),
        .i_rad   (r_s4.rad),
        .i_side  (r_s4.side),
        .o_valid (w_sq_valid),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // ------------------------------------------------------------------
    // Stage 5: range numerator and partial products of atten * d2.
    // ------------------------------------------------------------------
    logic        r_s5_valid;
    t_s5         r_s5;
    t_s5         n_s5;
    logic [31:0] w_rdiff;

    // Only used when the point is within range, where d <= range holds.
    assign w_rdiff = w_sq_side.range - w_sq_root[31:0];

    always_comb begin
        n_s5.kind  = w_sq_side.kind;
        n_s5.dotsh = w_sq_side.dotsh;
        n_s5.d     = w_sq_root;
        n_s5.rnum  = {1'b0, w_rdiff, {RF_FRAC{1'b0}}};
        n_s5.range = w_sq_side.range;
        n_s5.power = w_sq_side.power;
        n_s5.pp_lo = w_sq_side.atten * w_sq_side.s[31:0];
        n_s5.pp_hi = w_sq_side.atten * w_sq_side.s[S_W-1:32];
    end

    // ------------------------------------------------------------------
    // Stage 6: attenuation term, saturated at 2^62, and the denominator.
    // ------------------------------------------------------------------
    logic              r_s6_valid;
    t_s6               r_s6;
    t_s6               n_s6;
    logic [PROD_W-1:0] w_prod;
    logic [CMP_W-1:0]  w_term;
    logic              w_term_sat;
    logic [DEN_W-1:0]  w_term_clip;

    assign w_prod      = PROD_W'(r_s5.pp_lo) + {r_s5.pp_hi, 32'd0};
    assign w_term      = CMP_W'(w_prod[PROD_W-1:FRAC_BITS]);
    assign w_term_sat  = (w_term > (CMP_W'(1) << 62));
    assign w_term_clip = w_term_sat ? (DEN_W'(1) << 62) : w_term[DEN_W-1:0];

    always_comb begin
        n_s6.kind  = r_s5.kind;
        n_s6.dotsh = r_s5.dotsh;
        n_s6.d     = r_s5.d;
        n_s6.rnum  = r_s5.rnum;
        n_s6.range = r_s5.range;
        n_s6.power = r_s5.power;
        n_s6.den   = (DEN_W'(1) << FRAC_BITS) + w_term_clip;
    end

    // ------------------------------------------------------------------
    // N.L = N.v / d and the range factor (range - d) / range, side by side.
    // Both dividers have the same depth, so their outputs stay aligned.
    // ------------------------------------------------------------------
    t_ndl_side            w_ndl_side_in;
    t_ndl_side            w_ndl_side;
    logic                 w_ndl_valid;
    logic [NDL_NUM_W-1:0] w_ndl;
    logic                 w_rf_valid;
    logic [RF_NUM_W-1:0]  w_rf;
    logic [DEN_W-1:0]     w_rf_den_side;

    always_comb begin
        w_ndl_side_in.kind     = r_s6.kind;
        w_ndl_side_in.power    = r_s6.power;
        w_ndl_side_in.range_nz = (r_s6.range != '0);
    end

    plc_div #(
        .NUM_W  (NDL_NUM_W),
        .DEN_W  (ROOT_W),
        .SIDE_W ($bits(t_ndl_side))
    ) u_div_ndl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_s6_valid),
        .i_num   (r_s6.dotsh),
        .i_den   (r_s6.d),
        .i_side  (w_ndl_side_in),
        .o_valid (w_ndl_valid),
        .o_quot  (w_ndl),
        .o_side  (w_ndl_side)
    );

    plc_div #(
        .NUM_W  (RF_NUM_W),
        .DEN_W  (32),
        .SIDE_W (DEN_W)
    ) u_div_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_s6_valid),
        .i_num   (r_s6.rnum),
        .i_den   (r_s6.range),
        .i_side  (r_s6.den),
        .o_valid (w_rf_valid),
        .o_quot  (w_rf),
        .o_side  (w_rf_den_side)
    );

    // ------------------------------------------------------------------
    // Stage 7: intensity times N.L (kept modulo 2^64) and the squared range
    // factor.
    // ------------------------------------------------------------------
    logic        r_s7_valid;
    t_s7         r_s7;
    t_s7         n_s7;
    logic [62:0] w_ppb;
    logic [61:0] w_rfsq;

    assign w_ppb  = w_ndl_side.power * w_ndl[NDL_NUM_W-1:32];
    assign w_rfsq = w_rf[RF2_W-1:0] * w_rf[RF2_W-1:0];

    always_comb begin
        n_s7.kind     = w_ndl_side.kind;
        n_s7.power    = w_ndl_side.power;
        n_s7.range_nz = w_ndl_side.range_nz;
        n_s7.pp_a     = w_ndl_side.power * w_ndl[31:0];
        n_s7.pp_b     = w_ppb[31:0];
        n_s7.rf2      = w_rfsq[RF_FRAC+RF2_W-1:RF_FRAC];
        n_s7.den      = w_rf_den_side;
    end

    // ------------------------------------------------------------------
    // Stage 8: assemble the 64-bit numerator of the attenuation division.
    // ------------------------------------------------------------------
    logic r_s8_valid;
    t_s8  r_s8;
    t_s8  n_s8;

    always_comb begin
        n_s8.pnum          = r_s7.pp_a + {r_s7.pp_b, 32'd0};
        n_s8.den           = r_s7.den;
        n_s8.side.kind     = r_s7.kind;
        n_s8.side.power    = r_s7.power;
        n_s8.side.range_nz = r_s7.range_nz;
        n_s8.side.rf2      = r_s7.rf2;
    end

    // ------------------------------------------------------------------
    // Attenuated brightness b = intensity * N.L / den.
    // ------------------------------------------------------------------
    logic              w_b_valid;
    logic [PNUM_W-1:0] w_b;
    t_b_side           w_b_side;

    plc_div #(
        .NUM_W  (PNUM_W),
        .DEN_W  (DEN_W),
        .SIDE_W ($bits(t_b_side))
    ) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_s8_valid),
        .i_num   (r_s8.pnum),
        .i_den   (r_s8.den),
        .i_side  (r_s8.side),
        .o_valid (w_b_valid),
        .o_quot  (w_b),
        .o_side  (w_b_side)
    );

    // ------------------------------------------------------------------
    // Stage 9: partial products of b times the squared range factor.
    // ------------------------------------------------------------------
    logic r_s9_valid;
    t_s9  r_s9;
    t_s9  n_s9;

    always_comb begin
        n_s9.kind     = w_b_side.kind;
        n_s9.power    = w_b_side.power;
        n_s9.range_nz = w_b_side.range_nz;
        n_s9.b        = w_b;
        n_s9.pm_lo    = w_b[31:0] * w_b_side.rf2;
        n_s9.pm_hi    = w_b[63:32] * w_b_side.rf2;
    end

    // ------------------------------------------------------------------
    // Final stage: apply the range factor if the range is nonzero, scale to Q format,
    // saturate and select by kind. The result lands in the output skid stage.
    // ------------------------------------------------------------------
    logic [94:0] w_scaled;
    logic [63:0] w_bsel;
    logic        w_res_sat;
    logic [31:0] w_res;
    logic [31:0] w_fin;

    assign w_scaled  = 95'(r_s9.pm_lo) + {r_s9.pm_hi, 32'd0};
    assign w_bsel    = r_s9.range_nz ? w_scaled[RF_FRAC+63:RF_FRAC] : r_s9.b;
    assign w_res_sat = (w_bsel[63:OUT_SHIFT+32] != '0);
    assign w_res     = w_res_sat ? 32'hFFFF_FFFF : w_bsel[OUT_SHIFT+31:OUT_SHIFT];

    always_comb begin
        case (r_s9.kind)
            KIND_CALC:  w_fin = w_res;
            KIND_POWER: w_fin = r_s9.power;
            default:    w_fin = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage registers. Valid bits reset; payloads only follow the advance.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
            r_s8_valid <= 1'b0;
            r_s9_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_item.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= w_sq_valid;
            r_s6_valid <= r_s5_valid;
            r_s7_valid <= w_ndl_valid && w_rf_valid;
            r_s8_valid <= r_s7_valid;
            r_s9_valid <= w_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_s5 <= n_s5;
            r_s6 <= n_s6;
            r_s7 <= n_s7;
            r_s8 <= n_s8;
            r_s9 <= n_s9;
        end
    end

    // ------------------------------------------------------------------
    // Output skid stage. A finished result goes to the output register when
    // it is free or being transferred this cycle, otherwise to the spare
    // register, which stalls the pipeline until the output drains it.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_spare_valid <= 1'b0;
        end else if (r_spare_valid) begin
            if (w_out_take) begin
                r_out_valid   <= 1'b1;
                r_spare_valid <= 1'b0;
            end
        end else if (r_s9_valid) begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_spare_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_spare_valid) begin
            if (w_out_take) begin
                r_out_data <= r_spare_data;
            end
        end else if (r_s9_valid) begin
            if (!r_out_valid || w_out_take) begin
                r_out_data <= w_fin;
            end else begin
                r_spare_data <= w_fin;
            end
        end
    end

    assign o_item.valid        = r_out_valid;
    assign o_item.contribution = r_out_data;
endmodule

[design/plc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_checker
// Port-level checks of the point light contribution core, bound to it.
// ----------------------------------------------------------------------------
module plc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_contribution
);
    // Items taken in and not yet delivered; the pipeline holds fewer than 256.
    logic [8:0] r_pending;
    logic [8:0] n_pending;

    always_comb begin
        n_pending = r_pending;
        if (i_in_valid && i_in_ready) begin
            n_pending = n_pending + 9'd1;
        end
        if (i_out_valid && i_out_ready) begin
            n_pending = n_pending - 9'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // A result waiting for the sink keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_contribution))
        else $error("output changed while stalled");

    // No result appears without an item that caused it.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 9'd0)
        else $error("result without a pending item");

    // With the output empty, the skid stage is empty and input is taken.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output is empty");

    // Reset leaves no result on the output.
    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");
endmodule

bind point_light_contribution_core plc_checker u_plc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_item.valid),
    .i_in_ready         (i_item.ready),
    .i_out_valid        (o_item.valid),
    .i_out_ready        (o_item.ready),
    .i_out_contribution (o_item.contribution)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the point light contribution core. Directed corner
// items and random light/point pairs go in through the input channel; a
// scoreboard computes each diffuse contribution with wide integer arithmetic
// and compares every output transfer against the oldest prediction.
// ----------------------------------------------------------------------------

class plc_scoreboard;
    logic [31:0] pending[$];
    int          mismatches;
    int          unexpected;

    // Floor square root of a value below 2^68.
    function automatic logic [33:0] isqrt(logic [67:0] v);
        logic [33:0]  r;
        logic [33:0]  t;
        logic [67:0]  sq;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            t  = r | (34'd1 << b);
            sq = 68'(t) * 68'(t);
            if (sq <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    // Predicted contribution for one light/point pair at Q16.16.
    function automatic logic [31:0] shade(
        logic signed [31:0] sx, logic signed [31:0] sy, logic signed [31:0] sz,
        logic signed [15:0] nx, logic signed [15:0] ny, logic signed [15:0] nz,
        logic signed [31:0] lx, logic signed [31:0] ly, logic signed [31:0] lz,
        logic [31:0] range, logic [31:0] power, logic [31:0] atten);
        logic signed [33:0]  vx, vy, vz;
        logic signed [63:0]  dot;
        logic        [67:0]  d2;
        logic        [33:0]  d;
        logic        [127:0] term;
        logic        [127:0] den;
        logic        [127:0] ndl;
        logic        [127:0] b;
        logic        [127:0] rf;
        logic        [127:0] rf2;
        logic        [127:0] res;
        vx  = 34'(lx) - 34'(sx);
        vy  = 34'(ly) - 34'(sy);
        vz  = 34'(lz) - 34'(sz);
        d2  = 68'(vx * vx) + 68'(vy * vy) + 68'(vz * vz);
        dot = 64'(vx) * 64'(nx) + 64'(vy) * 64'(ny) + 64'(vz) * 64'(nz);
        if (range != 0 && d2 > 68'(range) * 68'(range)) begin
            return 32'd0;
        end
        if (d2 < 68'd49) begin
            return power;
        end
        if (dot <= 0) begin
            return 32'd0;
        end
        d    = isqrt(d2);
        ndl  = (128'(dot) << 14) / 128'(d);
        term = (128'(atten) * 128'(d2 >> 16)) >> 16;
        if (term > (128'd1 << 62)) begin
            term = 128'd1 << 62;
        end
        den = (128'd1 << 16) + term;
        // The intensity product wraps at 64 bits before the division.
        b   = 128'(64'(128'(power) * ndl)) / den;
        if (range != 0) begin
            rf  = ((128'(range) - 128'(d)) << 30) / 128'(range);
            rf2 = (rf * rf) >> 30;
            b   = (b * rf2) >> 30;
        end
        res = b >> 12;
        return (res > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
    endfunction

    function void note_input(logic [31:0] expected);
        pending.push_back(expected);
    endfunction

    function void check_result(logic [31:0] actual);
        logic [31:0] expected;
        if (pending.size() == 0) begin
            unexpected++;
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR: output 0x%08h with no prediction waiting", actual);
            end
            return;
        end
        expected = pending.pop_front();
        if (actual !== expected) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR: contribution expected 0x%08h got 0x%08h", expected, actual);
            end
        end
    endfunction
endclass

module tb_top;
    logic i_clk;
    logic i_rst_n;

    plc_in_if  in_ch ();
    plc_out_if out_ch ();

    point_light_contribution_core #(.FRAC_BITS(16)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (in_ch.sink),
        .o_item (out_ch.source)
    );

    plc_scoreboard sb;
    int  idle_pct;       // chance in percent that a side skips a cycle
    bit  hold_sink;      // long receiver hold-off, set by the pressure process
    int  quiet_cycles;   // cycles with no transfer on either channel

    localparam int NUM_RANDOM = 1800;
    localparam int WATCHDOG   = 20000;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sequence of one input transfer: drive the payload, hold valid until accepted.
    task automatic send_item(
        logic signed [31:0] sx, logic signed [31:0] sy, logic signed [31:0] sz,
        logic signed [15:0] nx, logic signed [15:0] ny, logic signed [15:0] nz,
        logic signed [31:0] lx, logic signed [31:0] ly, logic signed [31:0] lz,
        logic [31:0] range, logic [31:0] power, logic [31:0] atten);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.surf_x        <= sx;
        in_ch.surf_y        <= sy;
        in_ch.surf_z        <= sz;
        in_ch.norm_x        <= nx;
        in_ch.norm_y        <= ny;
        in_ch.norm_z        <= nz;
        in_ch.light_x       <= lx;
        in_ch.light_y       <= ly;
        in_ch.light_z       <= lz;
        in_ch.light_range   <= range;
        in_ch.light_power   <= power;
        in_ch.falloff_coeff <= atten;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        // The transfer happened at this edge; record what it must produce.
        sb.note_input(sb.shade(sx, sy, sz, nx, ny, nz, lx, ly, lz, range, power, atten));
    endtask

    // Random pair: mostly a light at a moderate distance, sometimes raw noise.
    task automatic send_random();
        logic signed [31:0] sx, sy, sz, lx, ly, lz;
        logic signed [15:0] nx, ny, nz;
        logic [31:0] range, power, atten;
        int          spread;
        sx = $urandom;
        sy = $urandom;
        sz = $urandom;
        nx = 16'($urandom);
        ny = 16'($urandom);
        nz = 16'($urandom);
        power = $urandom;
        atten = $urandom;
        range = $urandom;
        if ($urandom_range(9) < 7) begin
            // Light near the surface point: exercises falloff and range fade.
            spread = $urandom_range(30, 4);
            sx = $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
            sy = $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
            sz = $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
            lx = sx + (($urandom >> (32 - spread)) - (32'd1 << (spread - 1)));
            ly = sy + (($urandom >> (32 - spread)) - (32'd1 << (spread - 1)));
            lz = sz + (($urandom >> (32 - spread)) - (32'd1 << (spread - 1)));
            atten = $urandom >> $urandom_range(31, 8);
            case ($urandom_range(3))
                0: range = 32'd0;
                1: range = 32'd1 << spread;
                2: range = $urandom >> (32 - spread - 1);
                default: range = $urandom;
            endcase
            if ($urandom_range(3) == 0) begin
                power = $urandom >> $urandom_range(20);
            end
        end else begin
            lx = $urandom;
            ly = $urandom;
            lz = $urandom;
            if ($urandom_range(1) == 0) begin
                range = 32'd0;
            end
        end
        send_item(sx, sy, sz, nx, ny, nz, lx, ly, lz, range, power, atten);
    endtask

    // Sink side: random stalls plus an optional long hold-off.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result(out_ch.contribution);
            end
            out_ch.ready <= !hold_sink && ($urandom_range(99) >= idle_pct);
        end
    end

    // Pressure: the receiver stops for far longer than the pipeline depth.
    initial begin
        hold_sink = 1'b0;
        wait (i_rst_n);
        repeat (400) @(posedge i_clk);
        hold_sink = 1'b1;
        repeat (600) @(posedge i_clk);
        hold_sink = 1'b0;
    end

    // Watchdog on cycles with no transfer at all.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        idle_pct  = 31;
        i_rst_n   <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.surf_x        <= '0;
        in_ch.surf_y        <= '0;
        in_ch.surf_z        <= '0;
        in_ch.norm_x        <= '0;
        in_ch.norm_y        <= '0;
        in_ch.norm_z        <= '0;
        in_ch.light_x       <= '0;
        in_ch.light_y       <= '0;
        in_ch.light_z       <= '0;
        in_ch.light_range   <= '0;
        in_ch.light_power   <= '0;
        in_ch.falloff_coeff <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: light at the point, just inside and just outside the near radius.
        send_item(0, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 0, 0, 0, 0, 32'h0001_0000, 0);
        send_item(0, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 6, 0, 0, 0, 32'hFFFF_FFFF, 0);
        send_item(0, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 7, 0, 0, 0, 32'h0001_0000, 0);
        // Normal facing away and perpendicular.
        send_item(0, 0, 0, -16'sd16384, 16'sd0, 16'sd0, 32'h0001_0000, 0, 0, 0,
                  32'h0001_0000, 0);
        send_item(0, 0, 0, 16'sd0, 16'sd16384, 16'sd0, 32'h0001_0000, 0, 0, 0,
                  32'h0001_0000, 0);
        // Range: exactly on the boundary, one LSB beyond, well inside.
        send_item(0, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 32'h0002_0000, 0, 0, 32'h0002_0000,
                  32'h0001_0000, 0);
        send_item(0, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 32'h0002_0001, 0, 0, 32'h0002_0000,
                  32'h0001_0000, 0);
        send_item(0, 0, 0, 16'sd16384, 16'sd16384, 16'sd0, 32'h0001_0000, 32'h0001_0000, 0,
                  32'h0010_0000, 32'h0004_0000, 32'h0000_8000);
        // Extreme coordinates: largest distance, saturating attenuation term.
        send_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  16'sd32767, 16'sd32767, 16'sd32767,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        send_item(32'sh7FFF_FFFF, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 32'sh8000_0000,
                  32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        // Result saturation: huge power, strong oversized normal, short distance.
        send_item(0, 0, 0, 16'sd32767, 16'sd32767, 16'sd32767, 32'h0000_0100, 32'h0000_0100,
                  32'h0000_0100, 0, 32'hFFFF_FFFF, 0);
        // Zero power, maximum range with zero attenuation.
        send_item(0, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 32'h0100_0000, 0, 0, 32'hFFFF_FFFF,
                  0, 0);
        send_item(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_ABCD,
                  16'sd1000, -16'sd2000, 16'sd12000,
                  32'sh1334_5678, -32'sh0665_4321, 32'sh0100_ABCD, 32'hFFFF_FFFF,
                  32'h00FF_0000, 32'h0000_0001);

        // Random: a burst with no idling, then the usual idling mix.
        idle_pct = 0;
        for (int i = 0; i < 300; i++) begin
            send_random();
        end
        idle_pct = 31;
        for (int i = 300; i < NUM_RANDOM; i++) begin
            send_random();
        end
        in_ch.valid <= 1'b0;

        while (sb.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

[filelist.f]
design/plc_pkg.sv
design/plc_if.sv
design/plc_isqrt.sv
design/plc_div.sv
design/point_light_contribution_core.sv
design/plc_checker.sv
test/tb_top.sv
